// ----- rtl/hchd_pkg.sv -----
// Shared constants for the chunked body decoder.
package hchd_pkg;

   localparam int SIZE_WIDTH = 32;
   localparam int NIBBLE_WIDTH = 4;
   localparam int LINE_WIDTH = 8;
   localparam logic [7:0] HEADER_LIMIT_RESET = 8'd80;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   typedef enum logic [2:0] {
      STATUS_SIZE  = 3'd0,
      STATUS_DATA  = 3'd1,
      STATUS_TERM  = 3'd2,
      STATUS_TRAIL = 3'd3,
      STATUS_DONE  = 3'd4,
      STATUS_ERROR = 3'd5
   } status_type;

endpackage

// ----- rtl/hchd_if.sv -----
// Item channels of the chunked body decoder: input bytes, results and register writes.
interface hchd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface hchd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       payload_valid;
   logic [2:0] status;
   logic       message_end;

   modport source (output valid, output out_byte, output payload_valid, output status,
                   output message_end, input ready);
   modport sink (input valid, input out_byte, input payload_valid, input status,
                 input message_end, output ready);
endinterface

interface hchd_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] header_limit;

   modport source (output valid, output header_limit, input ready);
   modport sink (input valid, input header_limit, output ready);
endinterface

// ----- rtl/http_chunked_decoder.sv -----
// Chunked body decoder: one byte per item, status and payload flag per byte.
// Latency: a result is shown the cycle after its byte is accepted.
// Throughput: one byte per cycle; the phase register and the length counter update in one pass.
// A held result stalls input; a new byte is taken in the cycle the held result is read out.
// Reset (synchronous, active high) returns to the size line, clears all counters,
// sets header_limit to 80 and drops rsp.valid.
module http_chunked_decoder (
   input  logic             clock,
   input  logic             reset,
   hchd_req_if.sink         req,
   hchd_rsp_if.source       rsp,
   hchd_csr_if.sink         csr
);

   localparam int W = hchd_pkg::SIZE_WIDTH;
   localparam int NW = hchd_pkg::NIBBLE_WIDTH;

   typedef enum logic [2:0] {
      PH_SIZE  = 3'd0,
      PH_DATA  = 3'd1,
      PH_TERM  = 3'd2,
      PH_TRAIL = 3'd3,
      PH_DONE  = 3'd4,
      PH_ERR   = 3'd5
   } phase_type;

   phase_type                         phase_ff, phase_in;
   logic [W-1:0]                      chunk_ff, chunk_in;
   logic [hchd_pkg::LINE_WIDTH-1:0]   line_count_ff, line_count_in;
   logic                              digits_ended_ff, digits_ended_in;
   logic                              cr_seen_ff, cr_seen_in;
   logic                              term_count_ff, term_count_in;
   logic                              at_line_start_ff, at_line_start_in;
   logic [7:0]                        header_limit_ff;

   logic                              rsp_valid_ff;
   logic [7:0]                        out_byte_ff;
   logic                              payload_ff, payload_in;
   hchd_pkg::status_type              status_ff, status_in;
   logic                              mend_ff, mend_in;

   logic                              req_ready;
   logic                              accept;
   logic [7:0]                        b;
   logic                              hex_ok;
   logic [NW-1:0]                     hex_val;
   logic                              line_done;

   assign req_ready = ~rsp_valid_ff | rsp.ready;
   assign req.ready = req_ready;
   assign accept = req.valid & req_ready;
   assign b = req.in_byte;
   assign csr.ready = 1'b1;

   always_comb begin
      hex_ok = 1'b1;
      hex_val = '0;
      if (b >= 8'h30 && b <= 8'h39) begin
         hex_val = NW'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         hex_val = NW'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         hex_val = NW'(b - 8'h37);
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign line_done = (b == hchd_pkg::CHAR_LF) && cr_seen_ff;

   always_comb begin
      phase_in = phase_ff;
      chunk_in = chunk_ff;
      line_count_in = line_count_ff;
      digits_ended_in = digits_ended_ff;
      cr_seen_in = cr_seen_ff;
      term_count_in = term_count_ff;
      at_line_start_in = at_line_start_ff;
      payload_in = 1'b0;
      status_in = hchd_pkg::STATUS_SIZE;
      mend_in = 1'b0;
      case (phase_ff)
         PH_SIZE: begin
            status_in = hchd_pkg::STATUS_SIZE;
            if (!digits_ended_ff && hex_ok) begin
               if (|chunk_ff[W-1:W-NW]) begin
                  chunk_in = '1;
               end else begin
                  chunk_in = {chunk_ff[W-NW-1:0], hex_val};
               end
            end else begin
               digits_ended_in = 1'b1;
            end
            cr_seen_in = (b == hchd_pkg::CHAR_CR);
            line_count_in = line_count_ff + 1'b1;
            if (line_done) begin
               line_count_in = '0;
               digits_ended_in = 1'b0;
               cr_seen_in = 1'b0;
               if (chunk_in == '0) begin
                  phase_in = PH_TRAIL;
                  at_line_start_in = 1'b1;
               end else begin
                  phase_in = PH_DATA;
               end
            end else if (line_count_in >= header_limit_ff) begin
               phase_in = PH_ERR;
               status_in = hchd_pkg::STATUS_ERROR;
            end
         end
         PH_DATA: begin
            status_in = hchd_pkg::STATUS_DATA;
            payload_in = 1'b1;
            chunk_in = chunk_ff - 1'b1;
            if (chunk_in == '0) begin
               phase_in = PH_TERM;
               term_count_in = 1'b0;
            end
         end
         PH_TERM: begin
            status_in = hchd_pkg::STATUS_TERM;
            if (term_count_ff) begin
               term_count_in = 1'b0;
               phase_in = PH_SIZE;
               line_count_in = '0;
               digits_ended_in = 1'b0;
               cr_seen_in = 1'b0;
               chunk_in = '0;
            end else begin
               term_count_in = 1'b1;
            end
         end
         PH_TRAIL: begin
            status_in = hchd_pkg::STATUS_TRAIL;
            if (b == hchd_pkg::CHAR_CR) begin
               if (cr_seen_ff) begin
                  at_line_start_in = 1'b0;
               end
               cr_seen_in = 1'b1;
            end else if (line_done) begin
               cr_seen_in = 1'b0;
               if (at_line_start_ff) begin
                  mend_in = 1'b1;
                  phase_in = PH_DONE;
                  at_line_start_in = 1'b0;
               end else begin
                  at_line_start_in = 1'b1;
               end
            end else begin
               cr_seen_in = 1'b0;
               at_line_start_in = 1'b0;
            end
         end
         PH_DONE: begin
            status_in = hchd_pkg::STATUS_DONE;
         end
         default: begin
            phase_in = PH_ERR;
            status_in = hchd_pkg::STATUS_ERROR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SIZE;
         chunk_ff <= '0;
         line_count_ff <= '0;
         digits_ended_ff <= 1'b0;
         cr_seen_ff <= 1'b0;
         term_count_ff <= 1'b0;
         at_line_start_ff <= 1'b0;
         header_limit_ff <= hchd_pkg::HEADER_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr.valid) begin
            header_limit_ff <= csr.header_limit;
         end
         if (accept) begin
            phase_ff <= phase_in;
            chunk_ff <= chunk_in;
            line_count_ff <= line_count_in;
            digits_ended_ff <= digits_ended_in;
            cr_seen_ff <= cr_seen_in;
            term_count_ff <= term_count_in;
            at_line_start_ff <= at_line_start_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_byte_ff <= b;
         payload_ff <= payload_in;
         status_ff <= status_in;
         mend_ff <= mend_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.out_byte = out_byte_ff;
   assign rsp.payload_valid = payload_ff;
   assign rsp.status = status_ff;
   assign rsp.message_end = mend_ff;

   a_reset_drops_valid: assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("result valid after reset");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ERR |=> phase_ff == PH_ERR)
      else $error("error phase left without reset");

   a_data_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> chunk_ff != '0)
      else $error("data phase with zero remaining length");

   a_payload_is_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> payload_ff == (status_ff == hchd_pkg::STATUS_DATA))
      else $error("payload flag disagrees with status");

   a_end_in_trailer: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && mend_ff) |-> (status_ff == hchd_pkg::STATUS_TRAIL && phase_ff == PH_DONE))
      else $error("message end outside trailer");

endmodule
